// ===== hdl/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg
// shared types, constants and elaboration-time threshold tables of the
// track to calorimeter propagator
// ----------------------------------------------------------------------------
package ttc_pkg;

	// configuration register indexes
	typedef enum logic {
		REG_BARREL_RADIUS      = 1'b0,
		REG_ENDCAP_HALF_LENGTH = 1'b1
	} cfg_reg_t;

	// pt resolution bands
	typedef enum logic [1:0] {
		BAND_CENTRAL = 2'd0,
		BAND_OVERLAP = 2'd1,
		BAND_FORWARD = 2'd2
	} err_band_t;

	// sideband that travels with the tangent division
	typedef struct packed {
		logic               barrel;
		logic               big;
		logic               qneg;
		logic signed [15:0] tl;
	} tan_side_t;

	// phi turn search
	localparam int ASIN_BITS    = 10;
	localparam int ASIN_Q_W     = 44;
	localparam int ASIN_SAT_CNT = 1024;

	// eta search
	localparam int ETA_BITS  = 11;
	localparam int ETA_MAG_W = 24;

	// pt resolution
	localparam logic [10:0] ETA_BAND0_MAX = 11'd179;
	localparam logic [10:0] ETA_BAND1_MAX = 11'd307;
	localparam logic [8:0]  ERR_A0       = 9'd122;
	localparam logic [8:0]  ERR_A1       = 9'd143;
	localparam logic [8:0]  ERR_A2       = 9'd465;
	localparam logic signed [26:0] ERR_B0 = 27'sd10328;
	localparam logic signed [26:0] ERR_B1 = 27'sd8764;
	localparam logic signed [26:0] ERR_B2 = -27'sd308;
	localparam logic [24:0] ERR_HALF      = 25'd500;
	localparam logic [22:0] ERR_RECIP     = 23'd4294968;

	typedef logic [ASIN_Q_W-1:0]  asin_tab_t [2**ASIN_BITS];
	typedef logic [ETA_MAG_W-1:0] eta_tab_t  [2**ETA_BITS];

	// sin(h*pi/4096) in q30
	function automatic longint unsigned sin_q30(input longint unsigned h);
		longint unsigned t, t2, term, sum;
		t = h * 64'd3373259426 / 64'd4096;
		t2 = (t * t) >> 30;
		term = t;
		sum = t;
		for (int k = 1; k <= 8; k++) begin
			term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	// sinh(h/512) in q20
	function automatic longint unsigned sinh_q20(input longint unsigned h);
		longint unsigned e, e2, term, sum;
		e = h << 11;
		e2 = (e * e) >> 20;
		term = e;
		sum = e;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * e2) >> 20) / 64'((2 * k) * (2 * k + 1));
			sum = sum + term;
		end
		return sum;
	endfunction

	function automatic asin_tab_t build_asin_tab();
		asin_tab_t tab;
		tab[0] = '0;
		for (int k = 1; k < 2**ASIN_BITS; k++)
			tab[k] = ASIN_Q_W'(sin_q30(64'(2 * k - 1)) * 64'd1075);
		return tab;
	endfunction

	function automatic eta_tab_t build_eta_tab();
		eta_tab_t tab;
		tab[0] = '0;
		for (int k = 1; k < 2**ETA_BITS; k++)
			tab[k] = ETA_MAG_W'((sinh_q20(64'(2 * k - 1)) + 64'd255) >> 8);
		return tab;
	endfunction

	localparam asin_tab_t ASIN_TAB = build_asin_tab();
	localparam logic [ASIN_Q_W-1:0] ASIN_SAT = ASIN_Q_W'(sin_q30(64'd2047) * 64'd1075);
	localparam eta_tab_t ETA_TAB = build_eta_tab();

endpackage

// ===== hdl/track_to_calo_propagator.sv =====
// throughput: one track per cycle, busy is never raised
// tangent divider (29 stages), eta search (11 stages) and pt error stages set the depth
// reset clears the valid pipeline and loads the register defaults
// results cannot be held off, each beat shows for exactly one cycle
// ----------------------------------------------------------------------------
// track_to_calo_propagator
// converts a track to pt, pt error, eta and phi at the calorimeter face
// ----------------------------------------------------------------------------
module track_to_calo_propagator
	import ttc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] inv_curvature,
	input  logic signed [11:0] track_phi,
	input  logic signed [15:0] tan_lambda,
	input  logic signed [11:0] z_origin,
	input  logic               cfg_we,
	input  cfg_reg_t           cfg_idx,
	input  logic [13:0]        cfg_wdata,
	output logic               done,
	output logic [15:0]        pt_value,
	output logic [15:0]        pt_error,
	output logic signed [11:0] eta_at_calo,
	output logic signed [11:0] phi_at_calo,
	output logic signed [11:0] z_out
);

	localparam int PIPE_LAT = 52;

	logic [12:0] barrel_radius_q;
	logic [13:0] endcap_half_length_q;
	logic [PIPE_LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			barrel_radius_q      <= 13'd2064;
			endcap_half_length_q <= 14'd5134;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BARREL_RADIUS:      barrel_radius_q <= cfg_wdata[12:0];
				REG_ENDCAP_HALF_LENGTH: endcap_half_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[PIPE_LAT-2:0], start & ~busy};
	end

	// stage 1: input capture
	logic [15:0]        m_s1;
	logic               pos_s1, mz_s1;
	logic signed [11:0] phi_s1, z0_s1;
	logic signed [15:0] tl_s1;
	logic [12:0]        r_s1;
	logic [13:0]        zf_s1;

	always_ff @(posedge clk) begin
		m_s1   <= inv_curvature[15] ? 16'(-inv_curvature) : 16'(inv_curvature);
		pos_s1 <= !inv_curvature[15] && (inv_curvature != '0);
		mz_s1  <= inv_curvature == '0;
		phi_s1 <= track_phi;
		tl_s1  <= tan_lambda;
		z0_s1  <= z_origin;
		r_s1   <= (barrel_radius_q == '0) ? 13'd1 : barrel_radius_q;
		zf_s1  <= endcap_half_length_q;
	end

	// pt branch
	logic [16:0] pt_quo;
	logic        mz_d;
	logic [15:0] pt_s19, pt_d;

	ttc_div #(.NUM_W(17), .DEN_W(16)) u_pt_div (
		.clk (clk),
		.num (17'h10000 + {2'b0, m_s1[15:1]}),
		.den (m_s1),
		.quo (pt_quo)
	);

	ttc_delay #(.W(1), .N(17)) u_mz_dly (.clk(clk), .d(mz_s1), .q(mz_d));

	always_ff @(posedge clk)
		pt_s19 <= (mz_d || pt_quo[16]) ? 16'hFFFF : pt_quo[15:0];

	ttc_delay #(.W(16), .N(28)) u_pt_dly (.clk(clk), .d(pt_s19), .q(pt_d));

	// phi branch
	logic [28:0]        p_s2;
	logic [34:0]        p49_s3;
	logic [ASIN_BITS:0] dphi;
	logic [12:0]        phs_d;
	logic signed [11:0] ph_s14, ph_d;

	always_ff @(posedge clk) begin
		p_s2   <= {16'b0, r_s1} * {13'b0, m_s1};
		p49_s3 <= {6'b0, p_s2} * 35'd49;
	end

	ttc_asin_srch u_asin (.clk(clk), .q({p49_s3, 9'b0}), .dphi(dphi));

	ttc_delay #(.W(13), .N(12)) u_phs_dly (.clk(clk), .d({pos_s1, phi_s1}), .q(phs_d));

	always_ff @(posedge clk)
		ph_s14 <= phs_d[12] ? phs_d[11:0] + 12'(dphi) : phs_d[11:0] - 12'(dphi);

	ttc_delay #(.W(12), .N(37)) u_ph_dly (.clk(clk), .d(ph_s14), .q(ph_d));

	// tangent branch
	logic signed [29:0] rt_s2;
	logic signed [30:0] etl_s2, etl_s3;
	logic signed [15:0] tl_s2, tl_s3, dz_s3;
	logic signed [11:0] z0_s2, z0_s3;
	logic [12:0]        r_s2, r_s3;
	logic [13:0]        zf_s2;
	logic               barrel_s3;
	logic signed [31:0] lhs, zf4096;

	always_ff @(posedge clk) begin
		rt_s2  <= 30'($signed({1'b0, r_s1})) * 30'(tl_s1);
		etl_s2 <= 31'($signed({1'b0, zf_s1})) * 31'(tl_s1);
		tl_s2  <= tl_s1;
		z0_s2  <= z0_s1;
		r_s2   <= r_s1;
		zf_s2  <= zf_s1;
	end

	assign lhs    = $signed({{8{z0_s2[11]}}, z0_s2, 12'b0}) + 32'(rt_s2);
	assign zf4096 = $signed({6'b0, zf_s2, 12'b0});

	always_ff @(posedge clk) begin
		barrel_s3 <= lhs < zf4096;
		dz_s3     <= $signed({2'b0, zf_s2}) - 16'(z0_s2);
		etl_s3    <= etl_s2;
		tl_s3     <= tl_s2;
		z0_s3     <= z0_s2;
		r_s3      <= r_s2;
	end

	logic [11:0] z0_abs;
	logic [30:0] etl_abs;
	logic [28:0] dv_mag, dvd_s4;
	logic [14:0] dv_den, den_s4;
	tan_side_t   side_c, side_s4, side_d;

	assign z0_abs  = z0_s3[11] ? 12'(-z0_s3) : 12'(z0_s3);
	assign etl_abs = etl_s3[30] ? 31'(-etl_s3) : 31'(etl_s3);

	always_comb begin
		side_c.barrel = barrel_s3;
		side_c.big    = 1'b0;
		side_c.tl     = tl_s3;
		if (barrel_s3) begin
			dv_mag      = {5'b0, z0_abs, 12'b0};
			dv_den      = {2'b0, r_s3};
			side_c.qneg = z0_s3[11];
		end else if (dz_s3 > 16'sd0) begin
			dv_mag      = etl_abs[28:0];
			dv_den      = dz_s3[14:0];
			side_c.qneg = etl_s3[30];
		end else begin
			dv_mag      = '0;
			dv_den      = 15'd1;
			side_c.qneg = 1'b0;
			side_c.big  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		dvd_s4  <= dv_mag + {15'b0, dv_den[14:1]};
		den_s4  <= dv_den;
		side_s4 <= side_c;
	end

	logic [28:0] tan_quo;

	ttc_div #(.NUM_W(29), .DEN_W(15)) u_tan_div (
		.clk (clk),
		.num (dvd_s4),
		.den (den_s4),
		.quo (tan_quo)
	);

	ttc_delay #(.W($bits(tan_side_t)), .N(29)) u_side_dly (
		.clk (clk),
		.d   (side_s4),
		.q   (side_d)
	);

	logic signed [31:0] sq, tc_s34;
	logic               big_s34, tlneg_s34, tlnz_s34;
	logic [31:0]        tc_abs;
	logic               neg_s35, neg_d;
	logic [ETA_MAG_W-1:0] mag_s35;
	logic [ETA_BITS-1:0]  eta_cnt;

	assign sq = side_d.qneg ? -$signed({3'b0, tan_quo}) : $signed({3'b0, tan_quo});

	always_ff @(posedge clk) begin
		tc_s34    <= side_d.barrel ? sq + 32'(side_d.tl) : sq;
		big_s34   <= side_d.big;
		tlneg_s34 <= side_d.tl[15];
		tlnz_s34  <= side_d.tl != '0;
	end

	assign tc_abs = tc_s34[31] ? 32'(-tc_s34) : 32'(tc_s34);

	always_ff @(posedge clk) begin
		neg_s35 <= big_s34 ? tlneg_s34 : tc_s34[31];
		if (big_s34)
			mag_s35 <= {ETA_MAG_W{tlnz_s34}};
		else if (tc_abs[31:ETA_MAG_W] != '0)
			mag_s35 <= '1;
		else
			mag_s35 <= tc_abs[ETA_MAG_W-1:0];
	end

	ttc_asinh_srch u_asinh (.clk(clk), .mag(mag_s35), .cnt(eta_cnt));

	ttc_delay #(.W(1), .N(ETA_BITS)) u_neg_dly (.clk(clk), .d(neg_s35), .q(neg_d));

	logic signed [11:0] eta_s47;

	always_ff @(posedge clk)
		eta_s47 <= neg_d ? 12'(-{1'b0, eta_cnt}) : {1'b0, eta_cnt};

	// pt resolution
	logic [11:0]        eta_abs;
	err_band_t          band_s48, band_s49;
	logic [15:0]        pt_s48, pt_s49, pt_s50, pt_s51;
	logic signed [11:0] eta_s48, eta_s49, eta_s50, eta_s51;
	logic [8:0]         coef;
	logic [24:0]        prod_s49;
	logic signed [26:0] ofs, num;
	logic [24:0]        nclip, nhalf;
	logic [21:0]        nd8_s50;
	logic [44:0]        mul_s51;

	assign eta_abs = eta_s47[11] ? 12'(-eta_s47) : 12'(eta_s47);

	always_ff @(posedge clk) begin
		if (eta_abs[10:0] <= ETA_BAND0_MAX)
			band_s48 <= BAND_CENTRAL;
		else if (eta_abs[10:0] <= ETA_BAND1_MAX)
			band_s48 <= BAND_OVERLAP;
		else
			band_s48 <= BAND_FORWARD;
		pt_s48  <= pt_d;
		eta_s48 <= eta_s47;
	end

	always_comb begin
		case (band_s48)
			BAND_CENTRAL: coef = ERR_A0;
			BAND_OVERLAP: coef = ERR_A1;
			default:      coef = ERR_A2;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s49 <= {9'b0, pt_s48} * {16'b0, coef};
		band_s49 <= band_s48;
		pt_s49   <= pt_s48;
		eta_s49  <= eta_s48;
	end

	always_comb begin
		case (band_s49)
			BAND_CENTRAL: ofs = ERR_B0;
			BAND_OVERLAP: ofs = ERR_B1;
			default:      ofs = ERR_B2;
		endcase
	end

	assign num   = $signed({2'b0, prod_s49}) + ofs;
	assign nclip = num[26] ? '0 : num[24:0];
	assign nhalf = nclip + ERR_HALF;

	always_ff @(posedge clk) begin
		nd8_s50 <= nhalf[24:3];
		pt_s50  <= pt_s49;
		eta_s50 <= eta_s49;
	end

	always_ff @(posedge clk) begin
		mul_s51 <= {23'b0, nd8_s50} * {22'b0, ERR_RECIP};
		pt_s51  <= pt_s50;
		eta_s51 <= eta_s50;
	end

	// output beat
	logic signed [11:0] z_d;

	ttc_delay #(.W(12), .N(50)) u_z_dly (.clk(clk), .d(z0_s1), .q(z_d));

	always_ff @(posedge clk) begin
		pt_value    <= pt_s51;
		pt_error    <= mul_s51[44:29];
		eta_at_calo <= eta_s51;
		phi_at_calo <= ph_d;
		z_out       <= z_d;
	end

	assign done = vld_q[PIPE_LAT-1];

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_LAT))
		else $error("result beat without matching start");

	a_zero_curv_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[17] && mz_d |=> pt_s19 == 16'hFFFF)
		else $error("zero curvature pt not saturated");

	a_dphi_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[12] |-> dphi <= 11'd1024)
		else $error("phi turn beyond quarter turn");

	a_eta_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> eta_at_calo != 12'sh800)
		else $error("eta out of symmetric range");

endmodule

// ===== hdl/ttc_delay.sv =====
// ----------------------------------------------------------------------------
// ttc_delay
// fixed-length shift line for data that waits alongside a long unit
// ----------------------------------------------------------------------------
module ttc_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_q [N];

	always_ff @(posedge clk) begin
		dly_q[0] <= d;
		for (int i = 1; i < N; i++)
			dly_q[i] <= dly_q[i-1];
	end

	assign q = dly_q[N-1];

endmodule

// ===== hdl/ttc_div.sv =====
// ----------------------------------------------------------------------------
// ttc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ttc_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in, den_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W:0]   sh, diff;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign nq_in  = nq_s[i-1];
			assign den_in = den_s[i-1];
		end

		assign sh   = {rem_in, nq_in[NUM_W-1]};
		assign ge   = sh >= {1'b0, den_in};
		assign diff = sh - {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
			nq_s[i]  <= {nq_in[NUM_W-2:0], ge};
			den_s[i] <= den_in;
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

// ===== hdl/ttc_asin_srch.sv =====
// ----------------------------------------------------------------------------
// ttc_asin_srch
// phi turn: pipelined bitwise search of the scaled sine thresholds
// ----------------------------------------------------------------------------
module ttc_asin_srch
	import ttc_pkg::*;
(
	input  logic                clk,
	input  logic [ASIN_Q_W-1:0] q,
	output logic [ASIN_BITS:0]  dphi
);

	logic [ASIN_Q_W-1:0]  q_s   [ASIN_BITS];
	logic [ASIN_BITS-1:0] res_s [ASIN_BITS];
	logic                 sat_s [ASIN_BITS];

	for (genvar i = 0; i < ASIN_BITS; i++) begin : g_lvl
		logic [ASIN_Q_W-1:0]  q_in;
		logic [ASIN_BITS-1:0] res_in, cand;
		logic                 sat_in;

		if (i == 0) begin : g_first
			assign q_in   = q;
			assign res_in = '0;
			assign sat_in = q >= ASIN_SAT;
		end else begin : g_next
			assign q_in   = q_s[i-1];
			assign res_in = res_s[i-1];
			assign sat_in = sat_s[i-1];
		end

		assign cand = res_in | (ASIN_BITS'(1) << (ASIN_BITS - 1 - i));

		always_ff @(posedge clk) begin
			q_s[i]   <= q_in;
			sat_s[i] <= sat_in;
			res_s[i] <= (ASIN_TAB[cand] <= q_in) ? cand : res_in;
		end
	end

	assign dphi = sat_s[ASIN_BITS-1] ? (ASIN_BITS+1)'(ASIN_SAT_CNT)
		: {1'b0, res_s[ASIN_BITS-1]};

endmodule

// ===== hdl/ttc_asinh_srch.sv =====
// ----------------------------------------------------------------------------
// ttc_asinh_srch
// eta magnitude: pipelined bitwise search of the sinh thresholds
// ----------------------------------------------------------------------------
module ttc_asinh_srch
	import ttc_pkg::*;
(
	input  logic                 clk,
	input  logic [ETA_MAG_W-1:0] mag,
	output logic [ETA_BITS-1:0]  cnt
);

	logic [ETA_MAG_W-1:0] mag_s [ETA_BITS];
	logic [ETA_BITS-1:0]  res_s [ETA_BITS];

	for (genvar i = 0; i < ETA_BITS; i++) begin : g_lvl
		logic [ETA_MAG_W-1:0] mag_in;
		logic [ETA_BITS-1:0]  res_in, cand;

		if (i == 0) begin : g_first
			assign mag_in = mag;
			assign res_in = '0;
		end else begin : g_next
			assign mag_in = mag_s[i-1];
			assign res_in = res_s[i-1];
		end

		assign cand = res_in | (ETA_BITS'(1) << (ETA_BITS - 1 - i));

		always_ff @(posedge clk) begin
			mag_s[i] <= mag_in;
			res_s[i] <= (ETA_TAB[cand] <= mag_in) ? cand : res_in;
		end
	end

	assign cnt = res_s[ETA_BITS-1];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the track to calorimeter propagator: tracks are
// driven in random bursts, every done beat is compared field by field with
// a bit-exact software propagation under several barrel and endcap settings
// ----------------------------------------------------------------------------
module tb;
	import ttc_pkg::*;

	localparam int DRAIN_CYCLES = 70;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic signed [15:0] curv;
		logic signed [11:0] phi;
		logic signed [15:0] tanl;
		logic signed [11:0] z0;
	} track_t;

	typedef struct packed {
		logic [15:0]        pt;
		logic [15:0]        err;
		logic signed [11:0] eta;
		logic signed [11:0] phi;
		logic signed [11:0] z;
	} calo_hit_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] inv_curvature;
	logic signed [11:0] track_phi;
	logic signed [15:0] tan_lambda;
	logic signed [11:0] z_origin;
	logic               cfg_we;
	cfg_reg_t           cfg_idx;
	logic [13:0]        cfg_wdata;
	logic               done;
	logic [15:0]        pt_value;
	logic [15:0]        pt_error;
	logic signed [11:0] eta_at_calo;
	logic signed [11:0] phi_at_calo;
	logic signed [11:0] z_out;

	track_t    track_q[$];
	calo_hit_t hit_q[$];
	int        mismatches;
	int        beats_seen;
	int        tracks_sent;
	int        burst_left;
	int        gap_left;
	int        cycles;
	bit        hold;
	logic [12:0] radius_reg;
	logic [13:0] zface_reg;

	track_to_calo_propagator DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sin(h*pi/4096) as a q30 series
	function automatic longint unsigned circ_sine(input longint unsigned h);
		longint unsigned ang, sq, t, acc;
		ang = h * 64'd3373259426 / 64'd4096;
		sq = (ang * ang) >> 30;
		t = ang;
		acc = ang;
		for (int n = 1; n <= 8; n++) begin
			t = ((t * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
			acc = (n % 2) ? acc - t : acc + t;
		end
		return acc;
	endfunction

	// sinh(h/512) as a q20 series
	function automatic longint unsigned hyp_sine(input longint unsigned h);
		longint unsigned arg, sq, t, acc;
		arg = h << 11;
		sq = (arg * arg) >> 20;
		t = arg;
		acc = arg;
		for (int n = 1; n <= 24; n++) begin
			t = ((t * sq) >> 20) / longint'((2 * n) * (2 * n + 1));
			acc = acc + t;
		end
		return acc;
	endfunction

	function automatic longint rnd_div(input longint num, input longint den);
		longint q;
		q = ((num < 0 ? -num : num) + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic calo_hit_t propagate(input track_t tk, input logic [12:0] rreg,
			input logic [13:0] zreg);
		calo_hit_t h;
		longint r, zf, c, tl, z0, tc, eta, num, ae;
		longint unsigned m, pt, x, lo, hi, mid, mag, dphi, err;
		r = (rreg == 0) ? 1 : longint'(rreg);
		zf = longint'(zreg);
		c = tk.curv;
		tl = tk.tanl;
		z0 = tk.z0;
		m = c < 0 ? -c : c;
		pt = (m == 0) ? 65535 : (65536 + m / 2) / m;
		if (pt > 65535) pt = 65535;
		x = longint'(r) * m * 735 * 512 / 16125;
		if (x >= (64'd1 << 30)) begin
			dphi = 1024;
		end else begin
			lo = 0;
			hi = 2048;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (circ_sine(mid) <= x) lo = mid;
				else hi = mid - 1;
			end
			dphi = (lo + 1) >> 1;
		end
		h.phi = (c > 0) ? 12'(longint'(tk.phi) + longint'(dphi))
			: 12'(longint'(tk.phi) - longint'(dphi));
		if (z0 * 4096 + r * tl < zf * 4096)
			tc = tl + rnd_div(z0 * 4096, r);
		else if (zf - z0 > 0)
			tc = rnd_div(tl * zf, zf - z0);
		else
			tc = tl > 0 ? (64'sd1 <<< 40) : (tl < 0 ? -(64'sd1 <<< 40) : 0);
		mag = longint'(tc < 0 ? -tc : tc) << 8;
		lo = 0;
		hi = 4095;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (hyp_sine(mid) <= mag) lo = mid;
			else hi = mid - 1;
		end
		eta = longint'((lo + 1) >> 1);
		if (eta > 2047) eta = 2047;
		if (tc < 0) eta = -eta;
		ae = eta < 0 ? -eta : eta;
		if (ae * 10 < 1792) num = longint'(pt) * 122 + 10328;
		else if (ae * 10 < 3072) num = longint'(pt) * 143 + 8764;
		else num = longint'(pt) * 465 - 308;
		if (num < 0) num = 0;
		err = (num + 500) / 1000;
		if (err > 65535) err = 65535;
		h.pt = 16'(pt);
		h.err = 16'(err);
		h.eta = 12'(eta);
		h.z = tk.z0;
		return h;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch beat %0d %s: got %0d expected %0d", beats_seen, what, got, want);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (start && !busy) void'(track_q.pop_front());
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (hold || track_q.size() == 0) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				inv_curvature <= track_q[0].curv;
				track_phi <= track_q[0].phi;
				tan_lambda <= track_q[0].tanl;
				z_origin <= track_q[0].z0;
				burst_left--;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				hit_q.push_back(propagate({inv_curvature, track_phi, tan_lambda, z_origin},
					radius_reg, zface_reg));
				tracks_sent++;
			end
			if (done) begin
				if (hit_q.size() == 0) begin
					report("unexpected beat", 1, 0);
				end else begin
					calo_hit_t w;
					w = hit_q.pop_front();
					if (pt_value !== w.pt) report("pt_value", pt_value, w.pt);
					if (pt_error !== w.err) report("pt_error", pt_error, w.err);
					if (eta_at_calo !== w.eta) report("eta_at_calo", eta_at_calo, w.eta);
					if (phi_at_calo !== w.phi) report("phi_at_calo", phi_at_calo, w.phi);
					if (z_out !== w.z) report("z_out", z_out, w.z);
				end
				beats_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("track_to_calo_propagator verification failed");
			$finish;
		end
	end

	task automatic add_track(input int c, input int p, input int t, input int z);
		track_t tk;
		tk.curv = 16'(c);
		tk.phi = 12'(p);
		tk.tanl = 16'(t);
		tk.z0 = 12'(z);
		track_q.push_back(tk);
	endtask

	task automatic add_random(input int n);
		int c, t;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: c = $urandom_range(0, 65535) - 32768;
				1: c = $urandom_range(0, 127) - 64;
				2: c = $urandom_range(0, 4095) - 2048;
				default: c = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 12);
			endcase
			t = $urandom_range(0, 1) ? $urandom_range(0, 65535) - 32768
				: $urandom_range(0, 16383) - 8192;
			add_track(c, $urandom_range(0, 4095) - 2048, t, $urandom_range(0, 4095) - 2048);
		end
	endtask

	task automatic drain();
		wait (track_q.size() == 0 && !start && hit_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= 14'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BARREL_RADIUS) radius_reg = 13'(val);
		else zface_reg = 14'(val);
	endtask

	task automatic run_phase(input int r, input int z, input int n);
		drain();
		write_reg(REG_BARREL_RADIUS, r);
		write_reg(REG_ENDCAP_HALF_LENGTH, z);
		@(negedge clk);
		add_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		inv_curvature = '0;
		track_phi = '0;
		tan_lambda = '0;
		z_origin = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_BARREL_RADIUS;
		cfg_wdata = '0;
		hold = 1'b0;
		mismatches = 0;
		beats_seen = 0;
		tracks_sent = 0;
		cycles = 0;
		radius_reg = 13'd2064;
		zface_reg = 14'd5134;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// zero curvature, unit curvature both charges, extremes, looper
		add_track(0, 0, 0, 0);
		add_track(0, 2047, 32767, 2047);
		add_track(1, -2048, -32768, -2048);
		add_track(-1, 2047, 4096, 0);
		add_track(32767, 2047, 0, 0);
		add_track(-32768, -2048, 0, 0);
		add_track(20000, 1000, -4096, 100);
		add_track(-20000, -1000, 100, -100);
		add_track(2, 2040, 32767, -2048);
		add_track(-2, -2040, -32768, 2047);
		add_track(500, 0, 8192, 0);
		add_track(-500, 0, -8192, 0);
		add_track(64, 0, 1, 2047);
		add_track(-64, 0, -1, -2048);
		add_track(300, 5, 40000 - 65536, 1500);
		add_track(-7, -5, 2000, -1500);
		add_track(16, 100, 12000, 50);
		add_track(-16, -100, -12000, -50);
		add_random(60);
		// pause until every beat has come back
		wait (track_q.size() < 30);
		@(negedge clk);
		hold = 1'b1;
		wait (!start && hit_q.size() == 0);
		@(negedge clk);
		hold = 1'b0;
		run_phase(1, 2048, 65);
		run_phase(8191, 16383, 65);
		run_phase(0, 100, 65);
		run_phase(8191, 0, 40);
		run_phase($urandom_range(1, 8191), $urandom_range(2048, 16383), 65);
		drain();
		if (hit_q.size() != 0)
			report("beats never arrived", hit_q.size(), 0);
		$display("%0d tracks over six register settings, %0d beats checked, %0d mismatches",
			tracks_sent, beats_seen, mismatches);
		if (mismatches == 0)
			$display("track_to_calo_propagator verification clean");
		else
			$display("track_to_calo_propagator verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ttc_pkg.sv
hdl/ttc_delay.sv
hdl/ttc_div.sv
hdl/ttc_asin_srch.sv
hdl/ttc_asinh_srch.sv
hdl/track_to_calo_propagator.sv
tb/tb.sv
